>>> rtl/core/shbd_pkg.sv
// shared types and constants for the shift history button debouncer
// no dependencies
package shbd_pkg;

   localparam int NumButtonsDefault = 8;
   localparam int MaxButtons        = 8;
   localparam int HistWidth         = 16;

   localparam logic [HistWidth-1:0] HistRiseMatch = 16'h00ff;
   localparam logic [HistWidth-1:0] HistAllOnes   = 16'hffff;
   localparam logic [HistWidth-1:0] HistHighMask  = 16'hff00;
   localparam logic [HistWidth-1:0] HistLowMask   = 16'h00ff;
   localparam logic [HistWidth-1:0] HistAllZero   = 16'h0000;

   typedef enum logic [1:0] {
      PH_UNPRESSED = 2'd0,
      PH_RISING    = 2'd1,
      PH_PRESSED   = 2'd2,
      PH_FALLING   = 2'd3
   } phase_type;

   // first matching transition wins
   function automatic phase_type next_phase(input phase_type ph,
                                            input logic [HistWidth-1:0] h);
      phase_type nxt;
      nxt = ph;
      if (h == HistRiseMatch && ph == PH_UNPRESSED) begin
         nxt = PH_RISING;
      end else if (h == HistAllOnes && ph == PH_RISING) begin
         nxt = PH_PRESSED;
      end else if ((h & HistLowMask) == HistAllZero && (h & HistHighMask) != HistAllZero
                   && ph == PH_PRESSED) begin
         nxt = PH_FALLING;
      end else if (h == HistAllZero) begin
         nxt = PH_UNPRESSED;
      end
      return nxt;
   endfunction

endpackage

>>> rtl/core/shbd_button.sv
// one button: 16-bit pin history and four-state edge tracker
// depends on shbd_pkg
module shbd_button (
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  logic                pin,
   output shbd_pkg::phase_type phase_in,
   output logic                rose
);
   import shbd_pkg::*;

   logic [HistWidth-1:0] history_ff;
   logic [HistWidth-1:0] history_in;
   phase_type            phase_ff;

   // active-low pin shifts in a one
   assign history_in = {history_ff[HistWidth-2:0], ~pin};
   assign phase_in   = next_phase(phase_ff, history_in);
   assign rose       = (phase_ff == PH_UNPRESSED) && (phase_in == PH_RISING);

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= HistAllZero;
         phase_ff   <= PH_UNPRESSED;
      end else if (update) begin
         history_ff <= history_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

>>> rtl/core/shift_history_button_debouncer_unit.sv
// shift history button debouncer, top level
// input reg, then result reg; the per-button update is a single shift and compare
// throughput: one item per cycle unless rsp_tready stalls the output
// reset: synchronous active high, clears histories, phases, indicator and valids
// depends on shbd_pkg and shbd_button
module shift_history_button_debouncer_unit #(
   parameter int NUM_BUTTONS = shbd_pkg::NumButtonsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pin_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [15:0] button_states, [23:16] rising_mask,
                                    // [31:24] indicator_out
);
   import shbd_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  sample_ff;
   logic        out_valid_ff;
   logic [15:0] states_ff;
   logic [7:0]  rising_ff;
   logic [7:0]  indicator_ff;

   logic        out_free;
   logic        advance;
   logic [15:0] states_in;
   logic [7:0]  rising_in;
   logic [7:0]  indicator_in;

   phase_type              phases [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] rose;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
      shbd_button u_button (
         .clock    (clock),
         .reset    (reset),
         .update   (advance),
         .pin      (sample_ff[i]),
         .phase_in (phases[i]),
         .rose     (rose[i])
      );
   end

   always_comb begin
      states_in = '0;
      rising_in = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         states_in[2*i +: 2] = phases[i];
         rising_in[i]        = rose[i];
      end
      // an odd count of rising entries inverts the indicator
      indicator_in = indicator_ff ^ {8{^rising_in}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         indicator_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            indicator_ff <= indicator_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         sample_ff <= req_tdata;
      end
      if (advance) begin
         states_ff <= states_in;
         rising_ff <= rising_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {indicator_ff, rising_ff, states_ff};

endmodule
